/* hw/rtl/qdr_pkg.sv */
// shared constants and the step decode function of the quadrature decoder with rate estimate
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qdr_pkg;

  localparam int POS_W   = 32;
  localparam int DIR_W   = 2;
  localparam int VEL_W   = 40;
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 24;
  localparam int TIME_W  = 32;
  localparam int IVL_W   = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EVENT_PULSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALC_INTERVAL = 2'd1;

  localparam logic [IVL_W-1:0] CALC_INTERVAL_RST = 16'd10;

  localparam logic signed [VEL_W-1:0] V_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] V_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam int MS_PER_S = 1000;
  localparam int ACC_KEEP = 9;
  localparam int ACC_DIV  = 10;
  localparam int MEAN_DIV = 5;

  localparam logic signed [DIR_W-1:0] DIR_FWD = 2'sd1;
  localparam logic signed [DIR_W-1:0] DIR_REV = -2'sd1;

  // step per code {new b, new a, old b, old a}
  function automatic logic signed [2:0] step_delta(input logic [3:0] code);
    logic signed [2:0] d;
    begin
      case (code)
        4'd1, 4'd7, 4'd8, 4'd14: d = 3'sd1;
        4'd2, 4'd4, 4'd11, 4'd13: d = -3'sd1;
        4'd3, 4'd12: d = 3'sd2;
        4'd6, 4'd9: d = -3'sd2;
        default: d = 3'sd0;
      endcase
      return d;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/qdr_if.sv */
// valid/ready channels for encoder samples and decoder results
// depends on qdr_pkg
`timescale 1ns / 1ps
`default_nettype none
interface qdr_sample_if;
  logic valid;
  logic ready;
  logic level_a;
  logic level_b;
  logic [qdr_pkg::TIME_W-1:0] time_ms;
  modport source(output valid, output level_a, output level_b, output time_ms, input ready);
  modport sink(input valid, input level_a, input level_b, input time_ms, output ready);
endinterface

interface qdr_result_if;
  logic valid;
  logic ready;
  logic signed [qdr_pkg::POS_W-1:0] position;
  logic signed [qdr_pkg::DIR_W-1:0] direction;
  logic signed [qdr_pkg::VEL_W-1:0] velocity;
  logic signed [qdr_pkg::VEL_W-1:0] vel_avg;
  logic signed [qdr_pkg::ACC_W-1:0] acceleration;
  logic [qdr_pkg::CNT_W-1:0] pulses_left;
  logic event_fired;
  logic event_latched;
  logic rate_updated;
  modport source(output valid, output position, output direction, output velocity,
                 output vel_avg, output acceleration, output pulses_left,
                 output event_fired, output event_latched, output rate_updated,
                 input ready);
  modport sink(input valid, input position, input direction, input velocity,
               input vel_avg, input acceleration, input pulses_left,
               input event_fired, input event_latched, input rate_updated,
               output ready);
endinterface
`default_nettype wire

/* hw/rtl/quadrature_decoder_with_rate_estimate.sv */
// 4x quadrature decoder with pulse countdown and Q-format rate estimate
// depends on qdr_pkg and the channel interfaces in qdr_if
// Usage:
//   samples carries one item per encoder sample (levels a/b, ms timestamp);
//   results returns exactly one item per sample, in order.
//   cfg_we/cfg_index/cfg_data write event_pulses (index 0, also reloads the
//   countdown) and calc_interval_ms (index 1); other indexes are ignored.
// Sequencing:
//   a sample without a rate update passes the decode step and then the output
//   register; the next sample is accepted only once that result is registered.
//   a rate update divides by the elapsed time twice on a DW-bit restoring divider
//   (DW = max(51, 41 + FRAC_BITS)) and runs four divisions by a constant as
//   shift-add steps plus at most one correction.
//   samples.ready is high only while no sample is in work.
// Reset (rst, synchronous): decoder and rate state cleared, calc_interval_ms = 10,
//   event_pulses = 0, the next sample only primes the decoder.
// Stall: the finished result sits in the output register until taken;
//   a new sample may be accepted meanwhile and waits at its last step.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_decoder_with_rate_estimate #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  qdr_sample_if.sink samples,
  qdr_result_if.source results,
  input  wire logic cfg_we,
  input  wire logic [qdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qdr_pkg::CFG_W-1:0] cfg_data
);

  localparam int DW = (41 + FRAC_BITS > 51) ? 41 + FRAC_BITS : 51;
  localparam int SW = DW + 1;
  localparam int BCW = $clog2(DW + 1);
  localparam logic [BCW-1:0] BITS_LAST = BCW'(DW - 1);
  localparam logic signed [SW-1:0] VEL_SCALE = SW'(qdr_pkg::MS_PER_S) <<< FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;
  localparam logic [2:0] ST_CDIV = 3'd7;

  localparam logic [2:0] OP_VEL  = 3'd0;
  localparam logic [2:0] OP_INST = 3'd1;
  localparam logic [2:0] OP_AKEEP = 3'd2;
  localparam logic [2:0] OP_AINST = 3'd3;
  localparam logic [2:0] OP_MOLD = 3'd4;
  localparam logic [2:0] OP_MNEW = 3'd5;

  localparam logic signed [SW-1:0] V_HI = SW'(qdr_pkg::V_MAX);
  localparam logic signed [SW-1:0] V_LO = SW'(qdr_pkg::V_MIN);
  localparam logic signed [SW-1:0] A_HI = SW'(qdr_pkg::A_MAX);
  localparam logic signed [SW-1:0] A_LO = SW'(qdr_pkg::A_MIN);

  logic [2:0] state;
  logic [2:0] op;
  logic [BCW-1:0] bit_cnt;
  logic [2:0] cstep;

  // configuration
  logic [qdr_pkg::IVL_W-1:0] calc_interval_ms;

  // sample latch
  logic [1:0] smp_levels;
  logic [qdr_pkg::TIME_W-1:0] smp_time;

  // decoder state
  logic [1:0] prev_levels;
  logic primed;
  logic [qdr_pkg::POS_W-1:0] step_count;
  logic signed [qdr_pkg::DIR_W-1:0] step_dir;
  logic [qdr_pkg::CNT_W-1:0] countdown;
  logic event_flag;
  logic fired;
  logic updated;
  logic [qdr_pkg::TIME_W-1:0] ref_time;
  logic [qdr_pkg::POS_W-1:0] ref_position;
  logic [qdr_pkg::TIME_W-1:0] elapsed;
  logic signed [qdr_pkg::VEL_W-1:0] vel_now;
  logic signed [qdr_pkg::VEL_W-1:0] vel_mean;
  logic signed [qdr_pkg::ACC_W-1:0] acc_avg;

  // intermediate quotients
  logic signed [qdr_pkg::VEL_W-1:0] vel_new;
  logic signed [SW-1:0] inst;
  logic signed [SW-1:0] acc_keep;
  logic signed [SW-1:0] acc_inst;
  logic signed [qdr_pkg::VEL_W-1:0] mean_old;
  logic signed [qdr_pkg::VEL_W-1:0] mean_new;

  // shared divider
  logic [qdr_pkg::TIME_W-1:0] rem;
  logic [DW-1:0] quo;
  logic neg;
  logic [DW-1:0] cq;
  logic [DW-1:0] cr;

  logic signed [SW-1:0] dvd;
  logic [qdr_pkg::TIME_W:0] trial;
  logic ge;
  logic signed [SW-1:0] q_signed;
  logic signed [SW-1:0] acc_sum;
  logic signed [qdr_pkg::VEL_W+1:0] mean_sum;

  logic [3:0] code;
  logic signed [2:0] delta;
  logic [1:0] mag;
  logic [qdr_pkg::TIME_W-1:0] elapsed_now;

  assign samples.ready = (state == ST_IDLE);

  assign code = {smp_levels, prev_levels};
  assign delta = qdr_pkg::step_delta(code);
  assign mag = delta[2] ? 2'(-delta) : delta[1:0];
  assign elapsed_now = smp_time - ref_time;

  // the mean terms are doubled so that every constant division is by ten
  always_comb begin
    case (op)
      OP_VEL: dvd = SW'($signed(step_count - ref_position)) * VEL_SCALE;
      OP_INST: dvd = (SW'(vel_new) - SW'(vel_now)) * SW'(qdr_pkg::MS_PER_S);
      OP_AKEEP: dvd = SW'(acc_avg) * SW'(qdr_pkg::ACC_KEEP);
      OP_AINST: dvd = inst;
      OP_MOLD: dvd = SW'(vel_mean) * SW'(qdr_pkg::ACC_DIV / qdr_pkg::MEAN_DIV);
      default: dvd = SW'(vel_new) * SW'(qdr_pkg::ACC_DIV / qdr_pkg::MEAN_DIV);
    endcase
  end

  assign trial = {rem, quo[DW-1]};
  assign ge = (trial >= {1'b0, elapsed});
  assign q_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign acc_sum = acc_keep + acc_inst;
  assign mean_sum = (qdr_pkg::VEL_W+2)'(vel_mean) - (qdr_pkg::VEL_W+2)'(mean_old)
                    + (qdr_pkg::VEL_W+2)'(mean_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_VEL;
      bit_cnt <= '0;
      cstep <= '0;
      calc_interval_ms <= qdr_pkg::CALC_INTERVAL_RST;
      prev_levels <= '0;
      primed <= 1'b0;
      step_count <= '0;
      step_dir <= '0;
      countdown <= '0;
      event_flag <= 1'b0;
      fired <= 1'b0;
      updated <= 1'b0;
      ref_time <= '0;
      ref_position <= '0;
      elapsed <= '0;
      vel_now <= '0;
      vel_mean <= '0;
      acc_avg <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != ST_DONE) begin
        results.valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == qdr_pkg::REG_EVENT_PULSES) begin
          countdown <= cfg_data;
        end else if (cfg_index == qdr_pkg::REG_CALC_INTERVAL) begin
          calc_interval_ms <= cfg_data[qdr_pkg::IVL_W-1:0];
        end
      end

      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            smp_levels <= {samples.level_b, samples.level_a};
            smp_time <= samples.time_ms;
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          fired <= 1'b0;
          updated <= 1'b0;
          prev_levels <= smp_levels;
          if (!primed) begin
            primed <= 1'b1;
            ref_time <= smp_time;
            state <= ST_DONE;
          end else begin
            if (delta != 3'sd0) begin
              step_count <= step_count + qdr_pkg::POS_W'(delta);
              step_dir <= delta[2] ? qdr_pkg::DIR_REV : qdr_pkg::DIR_FWD;
              if (countdown != '0) begin
                if (countdown <= qdr_pkg::CNT_W'(mag)) begin
                  countdown <= '0;
                  event_flag <= 1'b1;
                  fired <= 1'b1;
                end else begin
                  countdown <= countdown - qdr_pkg::CNT_W'(mag);
                end
              end
            end
            elapsed <= elapsed_now;
            op <= OP_VEL;
            if (elapsed_now > qdr_pkg::TIME_W'(calc_interval_ms)) begin
              state <= ST_LOAD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LOAD: begin
          neg <= dvd[SW-1];
          quo <= dvd[SW-1] ? DW'(-dvd) : DW'(dvd);
          rem <= '0;
          bit_cnt <= '0;
          cstep <= '0;
          if (op == OP_VEL || op == OP_INST) begin
            state <= ST_DIV;
          end else begin
            state <= ST_CDIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle, dividend bits shift out the top of quo
          rem <= ge ? qdr_pkg::TIME_W'(trial - {1'b0, elapsed}) : trial[qdr_pkg::TIME_W-1:0];
          quo <= {quo[DW-2:0], ge};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BITS_LAST) begin
            state <= ST_WB;
          end
        end
        ST_CDIV: begin
          // magnitude / 10: estimate n * 0.8 / 8 from below, then fix up by one
          case (cstep)
            3'd0: cq <= {1'b0, quo[DW-1:1]} + {2'b0, quo[DW-1:2]};
            3'd1: cq <= cq + (cq >> 4);
            3'd2: cq <= cq + (cq >> 8);
            3'd3: cq <= cq + (cq >> 16);
            3'd4: cq <= cq + (cq >> 32);
            3'd5: cq <= cq >> 3;
            3'd6: cr <= quo - ((cq << 3) + (cq << 1));
            default: begin
              if (cr >= DW'(qdr_pkg::ACC_DIV)) begin
                cq <= cq + 1'b1;
                cr <= cr - DW'(qdr_pkg::ACC_DIV);
              end else begin
                quo <= cq;
                state <= ST_WB;
              end
            end
          endcase
          if (cstep != 3'd7) begin
            cstep <= cstep + 3'd1;
          end
        end
        ST_WB: begin
          case (op)
            OP_VEL: begin
              if (q_signed > V_HI) vel_new <= qdr_pkg::V_MAX;
              else if (q_signed < V_LO) vel_new <= qdr_pkg::V_MIN;
              else vel_new <= q_signed[qdr_pkg::VEL_W-1:0];
            end
            OP_INST: inst <= q_signed;
            OP_AKEEP: acc_keep <= q_signed;
            OP_AINST: acc_inst <= q_signed;
            OP_MOLD: mean_old <= q_signed[qdr_pkg::VEL_W-1:0];
            default: mean_new <= q_signed[qdr_pkg::VEL_W-1:0];
          endcase
          if (op == OP_MNEW) begin
            state <= ST_FIN;
          end else begin
            op <= op + 3'd1;
            state <= ST_LOAD;
          end
        end
        ST_FIN: begin
          if (acc_sum > A_HI) acc_avg <= qdr_pkg::A_MAX;
          else if (acc_sum < A_LO) acc_avg <= qdr_pkg::A_MIN;
          else acc_avg <= acc_sum[qdr_pkg::ACC_W-1:0];
          if (mean_sum > (qdr_pkg::VEL_W+2)'(qdr_pkg::V_MAX)) vel_mean <= qdr_pkg::V_MAX;
          else if (mean_sum < (qdr_pkg::VEL_W+2)'(qdr_pkg::V_MIN)) vel_mean <= qdr_pkg::V_MIN;
          else vel_mean <= mean_sum[qdr_pkg::VEL_W-1:0];
          vel_now <= vel_new;
          ref_time <= smp_time;
          ref_position <= step_count;
          updated <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            results.position <= step_count;
            results.direction <= step_dir;
            results.velocity <= vel_now;
            results.vel_avg <= vel_mean;
            results.acceleration <= acc_avg;
            results.pulses_left <= countdown;
            results.event_fired <= fired;
            results.event_latched <= event_flag;
            results.rate_updated <= updated;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sim/tb.sv */
// testbench for the quadrature decoder with rate estimate
// depends on qdr_pkg, the channel interfaces in qdr_if and the decoder top level
// a behavioral predictor builds the expected result of each accepted sample
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam logic [qdr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [qdr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int FRAC = 8;

  // position delta per {new b, new a, old b, old a}
  localparam int QUAD_STEP [16] = '{0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0};

  typedef struct {
    logic signed [qdr_pkg::POS_W-1:0] position;
    logic signed [qdr_pkg::DIR_W-1:0] direction;
    logic signed [qdr_pkg::VEL_W-1:0] velocity;
    logic signed [qdr_pkg::VEL_W-1:0] vel_avg;
    logic signed [qdr_pkg::ACC_W-1:0] acceleration;
    logic [qdr_pkg::CNT_W-1:0] pulses_left;
    logic event_fired;
    logic event_latched;
    logic rate_updated;
  } decoder_out_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [qdr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qdr_pkg::CFG_W-1:0] cfg_data;

  qdr_sample_if samples ();
  qdr_result_if results ();

  quadrature_decoder_with_rate_estimate #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .results(results),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  decoder_out_t pending_outputs[$];
  int mismatches;
  int snd_idle_pct;
  int rcv_idle_pct;
  int rcv_hold;
  logic [1:0] cur_levels;
  logic [qdr_pkg::TIME_W-1:0] cur_time;

  // predictor state
  logic [qdr_pkg::IVL_W-1:0] interval_reg;
  logic [1:0] m_levels;
  logic m_primed;
  logic [qdr_pkg::POS_W-1:0] m_pos;
  logic signed [qdr_pkg::DIR_W-1:0] m_dir;
  logic [qdr_pkg::CNT_W-1:0] m_countdown;
  logic m_latched;
  logic [qdr_pkg::TIME_W-1:0] m_ref_time;
  logic [qdr_pkg::POS_W-1:0] m_ref_pos;
  longint m_vel;
  longint m_vel_prev;
  longint m_mean;
  longint m_acc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predictor_reset();
    interval_reg = qdr_pkg::CALC_INTERVAL_RST;
    m_levels = '0;
    m_primed = 1'b0;
    m_pos = '0;
    m_dir = '0;
    m_countdown = '0;
    m_latched = 1'b0;
    m_ref_time = '0;
    m_ref_pos = '0;
    m_vel = 0;
    m_vel_prev = 0;
    m_mean = 0;
    m_acc = 0;
  endtask

  task automatic predict_sample(logic [1:0] lv, logic [qdr_pkg::TIME_W-1:0] t);
    decoder_out_t r;
    int d;
    int mag;
    logic [qdr_pkg::TIME_W-1:0] elapsed;
    logic signed [qdr_pkg::POS_W-1:0] dpos32;
    longint dpos;
    longint v;
    longint inst;
    r.event_fired = 1'b0;
    r.rate_updated = 1'b0;
    if (!m_primed) begin
      m_primed = 1'b1;
      m_levels = lv;
      m_ref_time = t;
    end else begin
      d = QUAD_STEP[{lv, m_levels}];
      m_levels = lv;
      if (d != 0) begin
        mag = d < 0 ? -d : d;
        m_pos = m_pos + qdr_pkg::POS_W'(d);
        m_dir = d > 0 ? qdr_pkg::DIR_FWD : qdr_pkg::DIR_REV;
        if (m_countdown != 0) begin
          if (m_countdown <= mag) begin
            m_countdown = '0;
            m_latched = 1'b1;
            r.event_fired = 1'b1;
          end else begin
            m_countdown = m_countdown - qdr_pkg::CNT_W'(mag);
          end
        end
      end
      elapsed = t - m_ref_time;
      if (elapsed > {16'd0, interval_reg}) begin
        dpos32 = m_pos - m_ref_pos;
        dpos = dpos32;
        v = clamp(dpos * qdr_pkg::MS_PER_S * (longint'(1) << FRAC) / longint'(elapsed),
                  longint'(qdr_pkg::V_MIN), longint'(qdr_pkg::V_MAX));
        inst = (v - m_vel_prev) * qdr_pkg::MS_PER_S / longint'(elapsed);
        m_acc = clamp(m_acc * qdr_pkg::ACC_KEEP / qdr_pkg::ACC_DIV + inst / qdr_pkg::ACC_DIV,
                      longint'(qdr_pkg::A_MIN), longint'(qdr_pkg::A_MAX));
        m_vel = v;
        m_vel_prev = v;
        m_mean = clamp(m_mean - m_mean / qdr_pkg::MEAN_DIV + v / qdr_pkg::MEAN_DIV,
                       longint'(qdr_pkg::V_MIN), longint'(qdr_pkg::V_MAX));
        m_ref_time = t;
        m_ref_pos = m_pos;
        r.rate_updated = 1'b1;
      end
    end
    r.position = m_pos;
    r.direction = m_dir;
    r.velocity = m_vel[qdr_pkg::VEL_W-1:0];
    r.vel_avg = m_mean[qdr_pkg::VEL_W-1:0];
    r.acceleration = m_acc[qdr_pkg::ACC_W-1:0];
    r.pulses_left = m_countdown;
    r.event_latched = m_latched;
    pending_outputs.push_back(r);
  endtask

  // receiver side: random stalls plus a counted hold-off
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold > 0) begin
        results.ready = 1'b0;
        rcv_hold--;
      end else begin
        results.ready = $urandom_range(99) >= rcv_idle_pct;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", name, e, a, $realtime);
    end
  endtask

  always @(posedge clk) begin
    decoder_out_t e;
    if (!rst && results.valid && results.ready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        e = pending_outputs.pop_front();
        check_field("position", e.position, results.position);
        check_field("direction", e.direction, results.direction);
        check_field("velocity", e.velocity, results.velocity);
        check_field("vel_avg", e.vel_avg, results.vel_avg);
        check_field("acceleration", e.acceleration, results.acceleration);
        check_field("pulses_left", e.pulses_left, results.pulses_left);
        check_field("event_fired", e.event_fired, results.event_fired);
        check_field("event_latched", e.event_latched, results.event_latched);
        check_field("rate_updated", e.rate_updated, results.rate_updated);
      end
    end
  end

  task automatic send_sample(logic [1:0] lv, logic [qdr_pkg::TIME_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      samples.valid = 1'b0;
      @(negedge clk);
    end
    samples.valid = 1'b1;
    samples.level_a = lv[0];
    samples.level_b = lv[1];
    samples.time_ms = t;
    do @(posedge clk); while (!samples.ready);
    predict_sample(lv, t);
    cur_levels = lv;
    cur_time = t;
  endtask

  // drops valid and waits until every expected item is back
  task automatic wait_results();
    @(negedge clk);
    samples.valid = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  // waits until every expected item is back and the block has settled
  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [qdr_pkg::CFG_IDX_W-1:0] idx, logic [qdr_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == qdr_pkg::REG_EVENT_PULSES) begin
      m_countdown = value;
    end else if (idx == qdr_pkg::REG_CALC_INTERVAL) begin
      interval_reg = value[qdr_pkg::IVL_W-1:0];
    end
  endtask

  function automatic logic [1:0] next_levels(logic [1:0] lv);
    int roll;
    roll = $urandom_range(99);
    // gray walk forward or back, otherwise noise or an unchanged level
    if (roll < 55) return {lv[0], ~lv[1]} ^ {1'b0, 1'b0} ^ (lv[0] ^ lv[1] ? 2'b10 : 2'b01) ^
                          {lv[0], ~lv[1]} ^ lv;
    if (roll < 85) return (lv[0] ^ lv[1]) ? lv ^ 2'b01 : lv ^ 2'b10;
    if (roll < 95) return 2'($urandom_range(3));
    return lv;
  endfunction

  function automatic logic [qdr_pkg::TIME_W-1:0] next_time(logic [qdr_pkg::TIME_W-1:0] t);
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return t + $urandom_range(3);
    if (roll < 90) return t + $urandom_range(40, 4);
    if (roll < 98) return t + $urandom_range(2000, 41);
    return $urandom;
  endfunction

  task automatic test_directed();
    int walk [17] = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
    write_reg(qdr_pkg::REG_EVENT_PULSES, 24'd3);
    write_reg(qdr_pkg::REG_CALC_INTERVAL, 24'd5);
    // every old/new level code once, first item primes
    send_sample(2'(walk[0]), 32'd0);
    for (int i = 1; i < 17; i++) send_sample(2'(walk[i]), cur_time + i % 4);
    // timestamp wrap around the top of the range
    send_sample(2'b01, 32'hFFFF_FFFF);
    send_sample(2'b11, 32'h0000_0009);
    send_sample(2'b10, 32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(qdr_pkg::REG_EVENT_PULSES, 24'hFF_FFFF);
    write_reg(qdr_pkg::REG_CALC_INTERVAL, 24'h00_FFFF);
    write_reg(REG_SPARE_2, 24'h00_0001);
    write_reg(REG_SPARE_3, 24'hFF_FFFF);
    repeat (6) send_sample(next_levels(cur_levels), cur_time + 32'd40000);
    wait_idle();
    write_reg(qdr_pkg::REG_EVENT_PULSES, 24'd0);
    write_reg(qdr_pkg::REG_CALC_INTERVAL, 24'd0);
    repeat (8) send_sample(next_levels(cur_levels), next_time(cur_time));
    wait_idle();
    // countdown of one hit by a double step clamps to zero
    write_reg(qdr_pkg::REG_EVENT_PULSES, 24'd1);
    send_sample(cur_levels ^ 2'b11, cur_time + 1);
    wait_idle();
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int count);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 75 == 0) begin
        wait_idle();
        write_reg(qdr_pkg::REG_EVENT_PULSES, ($urandom_range(9) == 0) ? 24'($urandom)
                                                             : 24'($urandom_range(60)));
        write_reg(qdr_pkg::REG_CALC_INTERVAL, ($urandom_range(9) == 0) ? 24'($urandom_range(65535))
                                                              : 24'($urandom_range(25)));
      end
      send_sample(next_levels(cur_levels), next_time(cur_time));
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rcv_hold = 800;
    repeat (12) send_sample(next_levels(cur_levels), next_time(cur_time));
    // sender pauses until every result item is back
    wait_results();
    repeat (5) send_sample(next_levels(cur_levels), next_time(cur_time));
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = qdr_pkg::REG_EVENT_PULSES;
    cfg_data = '0;
    samples.valid = 1'b0;
    samples.level_a = 1'b0;
    samples.level_b = 1'b0;
    samples.time_ms = '0;
    mismatches = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rcv_hold = 0;
    cur_levels = '0;
    cur_time = '0;
    predictor_reset();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_extremes();
    test_random(20, 74, 300);
    test_backpressure();
    test_random(74, 20, 300);
    test_random(0, 0, 300);

    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
